// ===== rtl/dac_pkg.sv =====
// shared types and constants of the distinct address counter
package dac_pkg;

  localparam int ADDR_W = 64;
  localparam int LOW_W = 32;
  localparam int MULT_W = 10;
  localparam logic [MULT_W-1:0] HASH_MULT = MULT_W'(997);
  localparam int PROD_W = LOW_W + MULT_W;
  localparam int DIGIT_W = 6;
  localparam int MOD_STEPS = (PROD_W + DIGIT_W - 1) / DIGIT_W;
  localparam int STEP_W = $clog2(MOD_STEPS);
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_BASE,
    ST_FILL,
    ST_SCAN,
    ST_CMP,
    ST_UPDATE,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/dac_req_if.sv =====
// request channel carrying one address
interface dac_req_if;
  logic                       valid;
  logic                       ready;
  logic [dac_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

// ===== rtl/dac_rsp_if.sv =====
// result channel carrying the count and the lookup flags
interface dac_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [dac_pkg::COUNT_W-1:0] distinct_count;
  logic                        was_new;
  logic                        bucket_overflow;

  modport source (output valid, output distinct_count, output was_new,
                  output bucket_overflow, input ready);
  modport sink (input valid, input distinct_count, input was_new,
                input bucket_overflow, output ready);
endinterface

// ===== rtl/dac_ram.sv =====
// generic simple dual port ram with registered read
module dac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/distinct_address_counter.sv =====
// distinct address counter: bounded hash set with a shared reduction unit
//
// Counts distinct 64-bit addresses. Each request is hashed from its low 32
// bits as (low * 997) mod NUM_BUCKETS and the full address is compared with
// the ways already held in that bucket, one way at a time through the single
// read port of the tag ram. A new address is appended and the 13-bit count
// rises (saturating at 8191); if the bucket already holds WAYS entries the
// address is reported new with overflow, and is neither stored nor counted.
// Every request returns one result. After reset the block sweeps the fill
// ram, one bucket per cycle, so ready stays low until the last bucket is clear.
// Each request passes in order through the multiply, the modulo (six
// product bits per cycle through one compare-subtract chain), the fill
// lookup, a scan and a compare per stored way up to the first hit, and
// the update and handoff, which waits until the output register is free.
// The next request is taken while a result still waits in the output
// register.
module distinct_address_counter #(
  parameter int NUM_BUCKETS = 1000,
  parameter int WAYS = 8
) (
  input logic        clk,
  input logic        rst,
  dac_req_if.sink    req,
  dac_rsp_if.source  rsp
);

  localparam int BKT_W = $clog2(NUM_BUCKETS);
  localparam int WAY_W = $clog2(WAYS + 1);
  localparam int TAG_DEPTH = NUM_BUCKETS * WAYS;
  localparam int TAG_AW = $clog2(TAG_DEPTH);
  localparam logic [BKT_W:0] NB_EXT = (BKT_W + 1)'(NUM_BUCKETS);
  localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(NUM_BUCKETS - 1);
  localparam logic [WAY_W-1:0] WAYS_C = WAY_W'(WAYS);
  localparam logic [TAG_AW-1:0] WAYS_A = TAG_AW'(WAYS);
  localparam logic [dac_pkg::STEP_W-1:0] LAST_STEP =
      dac_pkg::STEP_W'(dac_pkg::MOD_STEPS - 1);

  dac_pkg::state_t state, state_next;

  // per request registers
  logic [dac_pkg::ADDR_W-1:0] address;
  logic [dac_pkg::PROD_W-1:0] prod;
  logic [dac_pkg::STEP_W-1:0] step;
  logic [BKT_W-1:0]           rem, rem_next;
  logic [BKT_W-1:0]           bucket;
  logic [TAG_AW-1:0]          base;
  logic [WAY_W-1:0]           fill;
  logic [WAY_W-1:0]           way;
  logic                       found;
  logic [BKT_W-1:0]           clr_idx;
  logic [dac_pkg::COUNT_W-1:0] unique_total;

  // output register
  logic                        out_valid;
  logic [dac_pkg::COUNT_W-1:0] out_count;
  logic                        out_new;
  logic                        out_ovf;

  // sequencer outputs
  logic accept;
  logic out_load;
  logic store_new;
  logic fill_we;
  logic tag_we;

  // ram ports
  logic [BKT_W-1:0]  fill_waddr;
  logic [WAY_W-1:0]  fill_wdata;
  logic [WAY_W-1:0]  fill_rdata;
  logic [TAG_AW-1:0] tag_waddr;
  logic [TAG_AW-1:0] tag_raddr;
  logic [dac_pkg::ADDR_W-1:0] tag_rdata;

  logic hit;
  logic out_free;

  assign hit = (tag_rdata == address);
  assign out_free = !out_valid || rsp.ready;

  // shared reduction unit: folds the next product digit into the remainder
  always_comb begin
    logic [BKT_W:0] t;
    t = {1'b0, rem};
    for (int i = 0; i < dac_pkg::DIGIT_W; i++) begin
      t = {t[BKT_W-1:0], prod[dac_pkg::PROD_W-1-i]};
      if (t >= NB_EXT) begin
        t = t - NB_EXT;
      end
    end
    rem_next = t[BKT_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dac_pkg::ST_CLEAR: begin
        if (clr_idx == LAST_BKT) begin
          state_next = dac_pkg::ST_IDLE;
        end
      end
      dac_pkg::ST_IDLE: begin
        if (req.valid) begin
          state_next = dac_pkg::ST_MUL;
        end
      end
      dac_pkg::ST_MUL: state_next = dac_pkg::ST_MOD;
      dac_pkg::ST_MOD: begin
        if (step == LAST_STEP) begin
          state_next = dac_pkg::ST_BASE;
        end
      end
      dac_pkg::ST_BASE: state_next = dac_pkg::ST_FILL;
      dac_pkg::ST_FILL: state_next = dac_pkg::ST_SCAN;
      dac_pkg::ST_SCAN: begin
        if (way == fill) begin
          state_next = dac_pkg::ST_UPDATE;
        end else begin
          state_next = dac_pkg::ST_CMP;
        end
      end
      dac_pkg::ST_CMP: begin
        if (hit) begin
          state_next = dac_pkg::ST_UPDATE;
        end else begin
          state_next = dac_pkg::ST_SCAN;
        end
      end
      dac_pkg::ST_UPDATE: state_next = dac_pkg::ST_OUT;
      dac_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = dac_pkg::ST_IDLE;
        end
      end
      default: state_next = dac_pkg::ST_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    out_load = 1'b0;
    store_new = 1'b0;
    fill_we = 1'b0;
    fill_waddr = bucket;
    fill_wdata = fill + WAY_W'(1);
    unique case (state)
      dac_pkg::ST_CLEAR: begin
        // sweep every bucket to empty
        fill_we = 1'b1;
        fill_waddr = clr_idx;
        fill_wdata = '0;
      end
      dac_pkg::ST_IDLE: req.ready = 1'b1;
      dac_pkg::ST_UPDATE: begin
        store_new = !found && (fill < WAYS_C);
        fill_we = store_new;
      end
      dac_pkg::ST_OUT: out_load = out_free;
      default: ;
    endcase
  end

  assign accept = req.valid && req.ready;
  assign tag_we = store_new;
  assign tag_waddr = base + TAG_AW'(fill);
  assign tag_raddr = base + TAG_AW'(way);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dac_pkg::ST_CLEAR;
      clr_idx <= '0;
      unique_total <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == dac_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + BKT_W'(1);
      end
      if (store_new && unique_total != dac_pkg::COUNT_MAX) begin
        unique_total <= unique_total + dac_pkg::COUNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      address <= req.address;
      found <= 1'b0;
    end
    unique case (state)
      dac_pkg::ST_MUL: begin
        prod <= address[dac_pkg::LOW_W-1:0] * dac_pkg::HASH_MULT;
        rem <= '0;
        step <= '0;
      end
      dac_pkg::ST_MOD: begin
        rem <= rem_next;
        prod <= prod << dac_pkg::DIGIT_W;
        step <= step + dac_pkg::STEP_W'(1);
      end
      dac_pkg::ST_BASE: begin
        // fill ram read is issued at rem this cycle
        bucket <= rem;
        base <= TAG_AW'(rem) * WAYS_A;
      end
      dac_pkg::ST_FILL: begin
        fill <= (fill_rdata > WAYS_C) ? WAYS_C : fill_rdata;
        way <= '0;
      end
      dac_pkg::ST_CMP: begin
        if (hit) begin
          found <= 1'b1;
        end else begin
          way <= way + WAY_W'(1);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_count <= unique_total;
      out_new <= !found;
      out_ovf <= !found && (fill == WAYS_C);
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.distinct_count = out_count;
  assign rsp.was_new = out_new;
  assign rsp.bucket_overflow = out_ovf;

  // fill count per bucket, cleared by the sweep after reset
  dac_ram #(
    .WIDTH (WAY_W),
    .DEPTH (NUM_BUCKETS)
  ) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (rem),
    .rdata (fill_rdata)
  );

  // stored addresses, bucket-major; only ways below the fill count are compared
  dac_ram #(
    .WIDTH (dac_pkg::ADDR_W),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (address),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

`ifndef SYNTH
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> unique_total >= $past(unique_total))
    else $error("distinct count decreased");

  a_ovf_implies_new: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (!rsp.bucket_overflow || rsp.was_new))
    else $error("overflow reported for a known address");

  a_bucket_in_range: assert property (@(posedge clk) disable iff (rst)
    state == dac_pkg::ST_BASE |-> {1'b0, rem} < NB_EXT)
    else $error("bucket index out of range");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dac_pkg::ST_SCAN || state == dac_pkg::ST_CMP) |-> way <= fill)
    else $error("way scan ran past the fill count");

  a_hit_within_fill: assert property (@(posedge clk) disable iff (rst)
    (state == dac_pkg::ST_UPDATE && found) |-> way < fill)
    else $error("hit on a way that was never written");
`endif

endmodule

// ===== tb/distinct_address_counter_checker.sv =====
// checker for the distinct address counter: hash set prediction and result compare
`timescale 1ns / 100ps

module distinct_address_counter_checker #(
  parameter int NUM_BUCKETS = 1000,
  parameter int WAYS = 8
) (
  input  logic clk,
  input  logic rst,
  dac_req_if   req,
  dac_rsp_if   rsp,
  output int   failures,
  output int   outstanding
);

  typedef struct packed {
    logic [dac_pkg::COUNT_W-1:0] distinct_count;
    logic                        was_new;
    logic                        bucket_overflow;
  } lookup_result_t;

  // predicted hash set
  logic [dac_pkg::ADDR_W-1:0]  bucket_tags [NUM_BUCKETS][WAYS];
  int unsigned                 bucket_used [NUM_BUCKETS];
  logic [dac_pkg::COUNT_W-1:0] distinct_total;

  lookup_result_t     expected_results [$];

  function automatic lookup_result_t count_address(input logic [dac_pkg::ADDR_W-1:0] addr);
    int unsigned    bucket;
    int unsigned    used;
    bit             hit;
    lookup_result_t res;
    bucket = int'((64'(addr[dac_pkg::LOW_W-1:0]) * 64'(dac_pkg::HASH_MULT))
                  % 64'(NUM_BUCKETS));
    used = bucket_used[bucket];
    hit = 1'b0;
    for (int w = 0; w < used; w++)
      if (bucket_tags[bucket][w] == addr) hit = 1'b1;
    res.was_new = !hit;
    res.bucket_overflow = 1'b0;
    if (!hit) begin
      if (used < WAYS) begin
        bucket_tags[bucket][used] = addr;
        bucket_used[bucket] = used + 1;
        if (distinct_total != dac_pkg::COUNT_MAX) distinct_total = distinct_total + 1'b1;
      end else begin
        res.bucket_overflow = 1'b1;
      end
    end
    res.distinct_count = distinct_total;
    return res;
  endfunction

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      foreach (bucket_used[b]) bucket_used[b] = 0;
      distinct_total = '0;
      expected_results.delete();
      outstanding = 0;
    end else begin
      // results first, so a stray result is never matched to this edge's request
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual count %0d new %0b ovf %0b",
                   $time, rsp.distinct_count, rsp.was_new, rsp.bucket_overflow);
          failures++;
        end else begin
          want = expected_results.pop_front();
          compare_field("distinct_count", want.distinct_count, rsp.distinct_count);
          compare_field("was_new", want.was_new, rsp.was_new);
          compare_field("bucket_overflow", want.bucket_overflow, rsp.bucket_overflow);
        end
      end
      if (req.valid && req.ready)
        expected_results.push_back(count_address(req.address));
      outstanding = expected_results.size();
    end
  end

endmodule

// ===== tb/distinct_address_counter_tb.sv =====
// top of the distinct address counter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module distinct_address_counter_tb;

  localparam int NUM_BUCKETS = 1000;
  localparam int WAYS = 8;
  // a new address into a full bucket is the slowest request
  localparam int LOOKUP_CYCLES = 14 + 2 * WAYS;
  localparam int DRAIN_CYCLES = 4 * LOOKUP_CYCLES;
  // long enough for the clearing sweep after reset and the receiver hold-off
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOT_BUCKETS = 24;
  localparam int HISTORY_DEPTH = 256;
  localparam int SEGMENTS = 8;
  localparam int SEGMENT_ITEMS = 129;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic clk = 1'b0;
  logic rst;

  dac_req_if req_ch ();
  dac_rsp_if rsp_ch ();

  int fail_count;
  int pending_count;

  // idling odds in percent, set per segment by the stimulus process
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // raised by the stimulus when the long receiver hold-off should start
  bit hold_request = 1'b0;

  int stalled_cycles = 0;

  logic [dac_pkg::ADDR_W-1:0] sent_history [$];
  int unsigned                hot_residue [HOT_BUCKETS];

  always #1 clk = ~clk;

  distinct_address_counter #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS(WAYS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  distinct_address_counter_checker #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .WAYS(WAYS)
  ) chk (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .failures(fail_count),
    .outstanding(pending_count)
  );

  // offer one request and return at the edge that accepts it; ready is
  // looked at on the falling edge so the sample never races the block
  task automatic offer_address(input logic [dac_pkg::ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.address <= addr;
    @(negedge clk);
    while (!req_ch.ready) @(negedge clk);
    @(posedge clk);
    sent_history.push_back(addr);
    if (sent_history.size() > HISTORY_DEPTH) void'(sent_history.pop_front());
  endtask

  // receiver: random stalls per segment, and one long hold-off on request
  initial begin
    int held;
    bit hold_done;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        // keep ready low while the sender keeps pushing, so the output
        // register and then the input side of the block back up
        rsp_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done = 1'b1;
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: nothing moving on either channel for too long ends the run
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [dac_pkg::ADDR_W-1:0] directed_addrs [$];
    logic [dac_pkg::ADDR_W-1:0] addr;
    idle_mode_t                 mode;
    longint unsigned            low;
    int unsigned                pick;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.address <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part: extremes, duplicates, upper bits only in the compare,
    // and bucket 0 filled to its last way and then past it
    directed_addrs = '{
      64'h0000_0000_0000_0000,
      64'hFFFF_FFFF_FFFF_FFFF,
      64'h0000_0000_0000_0000,                  // duplicate of zero
      64'hFFFF_FFFF_FFFF_FFFF,                  // duplicate of all ones
      64'hFFFF_FFFF_0000_0000,                  // same bucket as zero, new tag
      64'h8000_0000_0000_0000,
      64'h0000_0000_0000_03E8,                  // low 1000, still bucket 0
      64'h0000_0000_0000_07D0,
      64'h0000_0000_0000_0BB8,
      64'h0000_0000_0000_0FA0,
      64'h0000_0000_0000_1388,                  // bucket 0 now holds every way
      64'h0000_0000_0000_1770,                  // new into a full bucket
      64'h0000_0000_0000_1770,                  // never stored, so overflow again
      64'h0000_0000_0000_03E8,                  // hit in a full bucket
      64'h0000_0000_0000_0000,
      64'h1234_5678_0000_0BB8,                  // upper bits differ, overflow
      64'h0000_0000_FFFF_FED8,                  // largest low word of bucket 0
      64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555
    };
    foreach (directed_addrs[i]) offer_address(directed_addrs[i]);

    foreach (hot_residue[h]) hot_residue[h] = $urandom_range(NUM_BUCKETS - 1);

    // random part in segments that walk through the idling modes twice
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      mode = idle_mode_t'(seg % 4);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        IDLE_SENDER: begin
          send_idle_pct = 84;
          recv_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          send_idle_pct = 0;
          recv_stall_pct = 84;
        end
        IDLE_BOTH: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
        end
      endcase
      // second pass without idling starts with the long receiver hold-off
      if (seg == 4) hold_request = 1'b1;

      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 35 && sent_history.size() > 0) begin
          // repeat an earlier address: hit, or overflow again if never stored
          addr = sent_history[$urandom_range(sent_history.size() - 1)];
        end else if (pick < 80) begin
          // new address into a hot bucket, so buckets fill and overflow
          low = hot_residue[$urandom_range(HOT_BUCKETS - 1)]
                + 64'd1000 * $urandom_range(4294966);
          addr[dac_pkg::LOW_W-1:0] = low[dac_pkg::LOW_W-1:0];
          addr[dac_pkg::ADDR_W-1:dac_pkg::LOW_W] =
              $urandom_range(1) ? $urandom : $urandom_range(3);
        end else begin
          addr = {$urandom, $urandom};
        end
        offer_address(addr);
      end
    end

    req_ch.valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // one more edge so the checker has seen the last request
    @(posedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
